### sv/efco_pkg.sv
package efco_pkg;

  // field widths
  localparam int AngW  = 24;
  localparam int PosW  = 32;
  localparam int VecW  = 16;
  localparam int CurW  = 16;
  localparam int CfgW  = 16;

  // cordic limits
  localparam int CordicStepsDef = 16;
  localparam int CordicStepsMax = 24;
  localparam int CordicW        = 34;
  localparam int ZW             = 28;

  // fixed constants
  localparam logic signed [VecW-1:0] OneQ14   = 16'sd16384;
  localparam logic signed [VecW-1:0] MinusOne = -16'sd16384;
  localparam int FullTurn    = 92160;
  localparam int HalfTurn    = 46080;
  localparam int QuarterTurn = 23040;
  localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;

  // command codes
  localparam logic CmdMouse = 1'b0;
  localparam logic CmdKeys  = 1'b1;

  // register indexes
  localparam logic RegSens  = 1'b0;
  localparam logic RegSpeed = 1'b1;

  // start and done between sequencer and cordic unit
  typedef struct packed {
    logic                   start;
    logic signed [AngW-1:0] angle;
  } trig_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [VecW-1:0] sin_v;
    logic signed [VecW-1:0] cos_v;
  } trig_rsp_t;

  // arctangent in Q.16 degrees
  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0:  atan_lut = 28'sd2949120;
      5'd1:  atan_lut = 28'sd1740967;
      5'd2:  atan_lut = 28'sd919879;
      5'd3:  atan_lut = 28'sd466945;
      5'd4:  atan_lut = 28'sd234379;
      5'd5:  atan_lut = 28'sd117304;
      5'd6:  atan_lut = 28'sd58666;
      5'd7:  atan_lut = 28'sd29335;
      5'd8:  atan_lut = 28'sd14668;
      5'd9:  atan_lut = 28'sd7334;
      5'd10: atan_lut = 28'sd3667;
      5'd11: atan_lut = 28'sd1833;
      5'd12: atan_lut = 28'sd917;
      5'd13: atan_lut = 28'sd458;
      5'd14: atan_lut = 28'sd229;
      5'd15: atan_lut = 28'sd115;
      5'd16: atan_lut = 28'sd57;
      5'd17: atan_lut = 28'sd29;
      5'd18: atan_lut = 28'sd14;
      5'd19: atan_lut = 28'sd7;
      5'd20: atan_lut = 28'sd4;
      5'd21: atan_lut = 28'sd2;
      5'd22: atan_lut = 28'sd1;
      default: atan_lut = 28'sd0;
    endcase
  endfunction

  // clamp a wide value to plus or minus one in Q1.14
  function automatic logic signed [VecW-1:0] clamp14(input logic signed [47:0] v);
    if (v > 48'sd16384)       clamp14 = OneQ14;
    else if (v < -48'sd16384) clamp14 = MinusOne;
    else                      clamp14 = v[VecW-1:0];
  endfunction

endpackage

### sv/efco_cordic.sv
module efco_cordic
  import efco_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  trig_req_t req_i,
  output trig_rsp_t rsp_o
);

  localparam int NSteps = (CORDIC_STEPS > CordicStepsMax) ? CordicStepsMax : CORDIC_STEPS;

  logic                      busy_q, busy_d;
  logic [4:0]                step_q, step_d;
  logic                      neg_q, neg_d;
  logic signed [CordicW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]      z_q, z_d;
  logic                      done_q, done_d;

  logic signed [AngW:0] r_mod, r_pos, t_fold;
  logic                 neg_fold;
  logic signed [CordicW-1:0] xs, ys;
  logic signed [CordicW-1:0] xr, yr;

  // angle reduction; a 24 bit angle is under 92 turns either way, done by compare
  // against a multiple found from the top bits, then one correction
  logic signed [AngW+8:0] quot_m;
  logic signed [AngW+8:0] rem_w;
  always_comb begin
    // reciprocal estimate of angle / 92160, floor, corrected below
    quot_m = 33'((34'(signed'(req_i.angle)) * 34'sd45) >>> 22);
    rem_w  = 33'(signed'(req_i.angle)) - quot_m * 33'sd92160;
    if (rem_w < 0)               rem_w = rem_w + 33'sd92160;
    if (rem_w >= 33'sd92160)     rem_w = rem_w - 33'sd92160;
    r_pos = rem_w[AngW:0];
    r_mod = r_pos;
    if (r_mod <= 25'sd23040) begin
      t_fold   = r_mod;
      neg_fold = 1'b0;
    end else if (r_mod <= 25'sd69120) begin
      t_fold   = r_mod - 25'sd46080;
      neg_fold = 1'b1;
    end else begin
      t_fold   = r_mod - 25'sd92160;
      neg_fold = 1'b0;
    end
  end

  // one rotation per cycle
  assign xs = x_q >>> step_q;
  assign ys = y_q >>> step_q;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    neg_d  = neg_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      neg_d  = neg_fold;
      x_d    = CordicGain;
      y_d    = '0;
      z_d    = ZW'(t_fold) <<< 8;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_lut(step_q);
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_lut(step_q);
      end
      step_d = step_q + 5'd1;
      if (step_q == 5'(NSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
  end

  // round to Q1.14
  logic signed [VecW-1:0] cx, cy;
  always_comb begin
    xr = (x_q + 34'sd32768) >>> 16;
    yr = (y_q + 34'sd32768) >>> 16;
    cx = clamp14(48'(xr));
    cy = clamp14(48'(yr));
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.cos_v = neg_q ? -cx : cx;
  assign rsp_o.sin_v = neg_q ? -cy : cy;

  ap_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("cordic restarted while busy");
  ap_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("cordic done held");
  ap_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q < 5'(NSteps)) else $error("cordic step out of range");

endmodule

### sv/euler_fly_camera_orientation_core.sv
// channel   | dir | handshake            | payload
// s_axis    | in  | tvalid / tready      | tdata item, tuser command
// m_axis    | out | tvalid / tready      | tdata result
// cfg       | in  | cfg_we_i             | cfg_idx_i, cfg_data_i
// the result is offered after a mouse item has updated its angles, or a key item has
// run its move steps, and then the shared cordic unit has run for yaw then pitch and
// the shared multiplier has run its steps
// reset puts the camera at (0,0,3) facing -z with yaw -90 degrees
// s_axis_tready is low from acceptance until the result has been taken
module euler_fly_camera_orientation_core
  import efco_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cursor_x[15:0], cursor_y[31:16], limit_pitch[32], key_mask[38:33],
  // frame_time[54:39], zero fill to 56
  input  logic [55:0]  s_axis_tdata,
  // command[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z (32 each), dir_x, dir_y, dir_z, side_x, side_z,
  // upv_x, upv_y, upv_z (16 each), yaw_out (24), lowest first
  output logic [247:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StMove  = 4'd1;
  localparam logic [3:0] StTrigY = 4'd2;
  localparam logic [3:0] StWaitY = 4'd3;
  localparam logic [3:0] StTrigP = 4'd4;
  localparam logic [3:0] StWaitP = 4'd5;
  localparam logic [3:0] StMul   = 4'd6;
  localparam logic [3:0] StOut   = 4'd7;

  logic [3:0] st_q, st_d;
  logic [3:0] ph_q, ph_d;

  logic [CfgW-1:0] sens_q, speed_q;
  logic signed [AngW-1:0] yaw_q, pitch_q;
  logic signed [PosW-1:0] pos_q [3];
  logic signed [VecW-1:0] dir_q [3];
  logic signed [VecW-1:0] side_q [2];
  logic signed [VecW-1:0] up_q [3];
  logic signed [CurW-1:0] lastx_q, lasty_q;
  logic first_q;

  logic [55:0] in_q;
  logic        cmd_q;
  logic signed [VecW-1:0] sy_q, cy_q, cp_q;
  logic signed [47:0] vel_q;
  logic signed [47:0] acc_q;
  logic signed [47:0] fwd_q [3];
  logic signed [47:0] rgt_q [2];
  logic signed [47:0] vert_q;
  logic               outv_q;

  trig_req_t treq;
  trig_rsp_t trsp;

  efco_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (treq),
    .rsp_o  (trsp)
  );

  // input fields
  logic signed [CurW-1:0] cur_x, cur_y;
  logic                   lim;
  logic [5:0]             keys;
  logic [15:0]            ftime;
  assign cur_x = in_q[15:0];
  assign cur_y = in_q[31:16];
  assign lim   = in_q[32];
  assign keys  = in_q[38:33];
  assign ftime = in_q[54:39];

  // shared multiplier, one product per cycle
  logic signed [39:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [57:0] mul_p;
  logic signed [47:0] prod;
  assign mul_p = mul_a * mul_b;
  assign prod  = mul_p[47:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      StMove: begin
        case (ph_q)
          4'd0: begin mul_a = 40'(speed_q); mul_b = 18'(ftime); end
          4'd1: begin mul_a = acc_q[39:0]; mul_b = 18'sd20; end
          4'd2: begin mul_a = vel_q[39:0]; mul_b = 18'(dir_q[0]); end
          4'd3: begin mul_a = vel_q[39:0]; mul_b = 18'(dir_q[1]); end
          4'd4: begin mul_a = vel_q[39:0]; mul_b = 18'(dir_q[2]); end
          4'd5: begin mul_a = vel_q[39:0]; mul_b = 18'(side_q[0]); end
          4'd6: begin mul_a = vel_q[39:0]; mul_b = 18'(side_q[1]); end
          default: begin mul_a = acc_q[39:0]; mul_b = 18'sd7; end
        endcase
      end
      StMul: begin
        case (ph_q)
          4'd0: begin mul_a = 40'(cy_q); mul_b = 18'(cp_q); end
          4'd1: begin mul_a = 40'(sy_q); mul_b = 18'(cp_q); end
          4'd2: begin mul_a = -40'(side_q[1]); mul_b = 18'(dir_q[1]); end
          4'd3: begin mul_a = 40'(side_q[0]); mul_b = 18'(dir_q[1]); end
          4'd4: begin mul_a = 40'(side_q[1]); mul_b = 18'(dir_q[0]); end
          default: begin mul_a = 40'(side_q[0]); mul_b = 18'(dir_q[2]); end
        endcase
      end
      default: ;
    endcase
  end

  // Q2.28 round to Q1.14 and clamp
  logic signed [VecW-1:0] r14;
  assign r14 = clamp14(48'((prod + 48'sd8192) >>> 14));

  // direction step, round to Q16.16
  logic signed [47:0] stp;
  assign stp = 48'((mul_p + 58'sd2097152) >>> 22);

  // mouse angle update
  logic signed [AngW+9:0] dyaw, dpitch, yaw_n, pitch_n;
  logic signed [CurW-1:0] lx, ly;
  logic signed [AngW-1:0] yaw_s, pitch_s, pitch_c, yaw_w;
  always_comb begin
    lx = first_q ? cur_x : lastx_q;
    ly = first_q ? cur_y : lasty_q;
    dyaw   = 34'(34'(signed'(17'(cur_x) - 17'(lx))) * signed'({1'b0, sens_q}));
    dpitch = 34'(34'(signed'(17'(ly) - 17'(cur_y))) * signed'({1'b0, sens_q}));
    yaw_n   = 34'(yaw_q) + dyaw;
    pitch_n = 34'(pitch_q) + dpitch;
    if (yaw_n > 34'sd8388607)       yaw_s = 24'sd8388607;
    else if (yaw_n < -34'sd8388608) yaw_s = -24'sd8388608;
    else                            yaw_s = yaw_n[AngW-1:0];
    if (pitch_n > 34'sd8388607)       pitch_s = 24'sd8388607;
    else if (pitch_n < -34'sd8388608) pitch_s = -24'sd8388608;
    else                              pitch_s = pitch_n[AngW-1:0];
    pitch_c = pitch_s;
    if (lim && pitch_s > 24'sd22784)  pitch_c = 24'sd22784;
    if (lim && pitch_s < -24'sd22784) pitch_c = -24'sd22784;
    yaw_w = yaw_s;
    if (yaw_w > 24'sd43520)  yaw_w = yaw_w - 24'sd92160;
    if (yaw_w < -24'sd43520) yaw_w = yaw_w + 24'sd92160;
  end

  // saturating position add
  function automatic logic signed [PosW-1:0] sat_add(input logic signed [PosW-1:0] p,
                                                     input logic signed [47:0] s);
    logic signed [48:0] t;
    t = 49'(p) + 49'(s);
    if (t > 49'sd2147483647)       sat_add = 32'sh7fffffff;
    else if (t < -49'sd2147483648) sat_add = 32'sh80000000;
    else                           sat_add = t[PosW-1:0];
  endfunction

  // position step applied in key order, one key per cycle
  logic signed [PosW-1:0] pos_n [3];
  always_comb begin
    pos_n[0] = pos_q[0];
    pos_n[1] = pos_q[1];
    pos_n[2] = pos_q[2];
    case (ph_q)
      4'd8: if (keys[0]) begin
        pos_n[0] = sat_add(pos_q[0], fwd_q[0]);
        pos_n[1] = sat_add(pos_q[1], fwd_q[1]);
        pos_n[2] = sat_add(pos_q[2], fwd_q[2]);
      end
      4'd9: if (keys[1]) begin
        pos_n[0] = sat_add(pos_q[0], -fwd_q[0]);
        pos_n[1] = sat_add(pos_q[1], -fwd_q[1]);
        pos_n[2] = sat_add(pos_q[2], -fwd_q[2]);
      end
      4'd10: if (keys[2]) begin
        pos_n[0] = sat_add(pos_q[0], rgt_q[0]);
        pos_n[2] = sat_add(pos_q[2], rgt_q[1]);
      end
      4'd11: if (keys[3]) begin
        pos_n[0] = sat_add(pos_q[0], -rgt_q[0]);
        pos_n[2] = sat_add(pos_q[2], -rgt_q[1]);
      end
      4'd12: if (keys[4]) pos_n[1] = sat_add(pos_q[1], vert_q);
      4'd13: if (keys[5]) pos_n[1] = sat_add(pos_q[1], -vert_q);
      default: ;
    endcase
  end

  // vertical step, vel * 14 / 2560 rounded; with vel = speed * time * 20
  // this is (speed * time * 7 + 32) >> 6
  logic signed [47:0] vq;
  assign vq = (prod + 48'sd32) >>> 6;

  // a mouse item first updates the angles, then starts the yaw rotation
  logic ang_upd;
  assign ang_upd = (st_q == StTrigY) && (ph_q == 4'd0) && (cmd_q == CmdMouse);

  assign treq.start = ((st_q == StTrigY) && !ang_upd) || (st_q == StTrigP);
  assign treq.angle = (st_q == StTrigY) ? yaw_q : pitch_q;

  // sequencer
  always_comb begin
    st_d = st_q;
    ph_d = ph_q;
    case (st_q)
      StIdle: if (s_axis_tvalid) begin
        st_d = (s_axis_tuser == CmdKeys) ? StMove : StTrigY;
        ph_d = '0;
      end
      StMove: begin
        ph_d = ph_q + 4'd1;
        if (ph_q == 4'd13) st_d = StTrigY;
      end
      StTrigY: begin
        if (ang_upd) ph_d = 4'd1;
        else         st_d = StWaitY;
      end
      StWaitY: if (trsp.done) st_d = StTrigP;
      StTrigP: st_d = StWaitP;
      StWaitP: if (trsp.done) begin
        st_d = StMul;
        ph_d = '0;
      end
      StMul: begin
        ph_d = ph_q + 4'd1;
        if (ph_q == 4'd5) st_d = StOut;
      end
      StOut: if (m_axis_tready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      ph_q    <= '0;
      sens_q  <= 16'd128;
      speed_q <= 16'd26;
      yaw_q   <= -24'sd23040;
      pitch_q <= '0;
      pos_q[0] <= '0;
      pos_q[1] <= '0;
      pos_q[2] <= 32'sd196608;
      dir_q[0] <= '0;
      dir_q[1] <= '0;
      dir_q[2] <= MinusOne;
      side_q[0] <= OneQ14;
      side_q[1] <= '0;
      up_q[0] <= '0;
      up_q[1] <= OneQ14;
      up_q[2] <= '0;
      lastx_q <= '0;
      lasty_q <= '0;
      first_q <= 1'b1;
      outv_q  <= 1'b0;
    end else begin
      st_q <= st_d;
      ph_q <= ph_d;
      outv_q <= (st_d == StOut);
      if (cfg_we_i) begin
        if (cfg_idx_i == RegSens) sens_q  <= cfg_data_i;
        else                      speed_q <= cfg_data_i;
      end
      if (ang_upd) begin
        yaw_q   <= yaw_w;
        pitch_q <= pitch_c;
        lastx_q <= cur_x;
        lasty_q <= cur_y;
        first_q <= 1'b0;
      end
      if (st_q == StMove) begin
        pos_q[0] <= pos_n[0];
        pos_q[1] <= pos_n[1];
        pos_q[2] <= pos_n[2];
      end
      if (st_q == StWaitP && trsp.done) begin
        dir_q[1]  <= trsp.sin_v;
        side_q[0] <= (trsp.cos_v < 0) ? sy_q : -sy_q;
        side_q[1] <= (trsp.cos_v < 0) ? -cy_q : cy_q;
      end
      if (st_q == StMul) begin
        case (ph_q)
          4'd0: dir_q[0] <= r14;
          4'd1: dir_q[2] <= r14;
          4'd2: up_q[0]  <= r14;
          4'd3: up_q[2]  <= r14;
          4'd5: up_q[1]  <= clamp14((acc_q - prod + 48'sd8192) >>> 14);
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && s_axis_tvalid) begin
      in_q  <= s_axis_tdata;
      cmd_q <= s_axis_tuser;
    end
    if (st_q == StWaitY && trsp.done) begin
      sy_q <= trsp.sin_v;
      cy_q <= trsp.cos_v;
    end
    if (st_q == StWaitP && trsp.done) begin
      cp_q <= trsp.cos_v;
    end
    if (st_q == StMul && ph_q == 4'd4) acc_q <= prod;
    if (st_q == StMove) begin
      case (ph_q)
        4'd0: acc_q  <= prod;
        4'd1: vel_q  <= prod;
        4'd2: fwd_q[0] <= stp;
        4'd3: fwd_q[1] <= stp;
        4'd4: fwd_q[2] <= stp;
        4'd5: rgt_q[0] <= stp;
        4'd6: rgt_q[1] <= stp;
        4'd7: vert_q <= vq;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (st_q == StIdle);
  assign m_axis_tvalid = (st_q == StOut);
  assign m_axis_tdata  = {yaw_q, up_q[2], up_q[1], up_q[0], side_q[1], side_q[0],
                          dir_q[2], dir_q[1], dir_q[0], pos_q[2], pos_q[1], pos_q[0]};

  ap_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
  ap_out_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> outv_q) else $error("output flag mismatch");
  ap_pitch_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StWaitP && trsp.done) |=> st_q == StMul) else $error("sequence slip");

endmodule

### tb/euler_fly_camera_orientation_core_tb.sv
module euler_fly_camera_orientation_core_tb;
  import efco_pkg::*;

  localparam int LimitCycles = 1000000;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic               lim;
    logic [5:0]         keys;
    logic [15:0]        ftime;
  } cam_item_t;

  typedef struct packed {
    logic signed [23:0] yaw;
    logic signed [15:0] upz, upy, upx;
    logic signed [15:0] sdz, sdx;
    logic signed [15:0] dz, dy, dx;
    logic signed [31:0] pz, py, px;
  } cam_view_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [247:0] m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic         cfg_idx_i = 1'b0;
  logic [15:0]  cfg_data_i = '0;

  euler_fly_camera_orientation_core dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // camera state mirror
  longint sens, speed, yaw, pitch, lastc[2], posv[3], dirv[3], sidev[2], upv[3];
  bit     fresh_cursor;

  cam_item_t pending_items[$];
  cam_view_t expected_views[$];
  int  fail_count = 0, mismatch_count = 0, cycle_count = 0;
  bit  hold_off = 0;
  bit  in_fire = 0, out_fire = 0;
  int  send_gap = 0, take_gap = 0;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint mulq14(longint a, longint b);
    return clip(shr_floor(a * b + 8192, 14), -16384, 16384);
  endfunction

  task automatic cordic_sin_cos(input longint ang, output longint s, output longint c);
    longint r, t, x, y, z, xs, ys;
    bit flip;
    r = ang % FullTurn;
    x = 652032874;
    y = 0;
    flip = 0;
    if (r < 0) r += FullTurn;
    if (r <= QuarterTurn) t = r;
    else if (r <= 3 * QuarterTurn) begin
      t = r - HalfTurn;
      flip = 1;
    end else t = r - FullTurn;
    z = t * 256;
    for (int i = 0; i < CordicStepsDef; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_lut(i[4:0]));
      end else begin
        x += ys; y -= xs; z += longint'(atan_lut(i[4:0]));
      end
    end
    x = clip(shr_floor(x + 32768, 16), -16384, 16384);
    y = clip(shr_floor(y + 32768, 16), -16384, 16384);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic void reset_camera();
    sens = 128; speed = 26; yaw = -23040; pitch = 0;
    posv = '{0, 0, 3 * 65536};
    dirv = '{0, 0, -16384};
    sidev = '{16384, 0};
    upv = '{0, 16384, 0};
    lastc = '{0, 0};
    fresh_cursor = 1;
  endfunction

  function automatic void nudge(int axis, longint step);
    posv[axis] = clip(posv[axis] + step, -64'sd2147483648, 64'sd2147483647);
  endfunction

  // advance the camera by one item and queue the view it must produce
  task automatic predict_view(input cam_item_t it);
    longint sy, cy, sp, cp, vel, vert, fwd[3], rgt[3];
    cam_view_t v;
    if (it.cmd == CmdMouse) begin
      if (fresh_cursor) begin
        lastc = '{it.cur_x, it.cur_y};
        fresh_cursor = 0;
      end
      yaw = clip(yaw + (it.cur_x - lastc[0]) * sens, -8388608, 8388607);
      pitch = clip(pitch + (lastc[1] - it.cur_y) * sens, -8388608, 8388607);
      lastc = '{it.cur_x, it.cur_y};
      if (it.lim) pitch = clip(pitch, -89 * 256, 89 * 256);
      if (yaw > 170 * 256) yaw -= FullTurn;
      if (yaw < -170 * 256) yaw += FullTurn;
    end else begin
      vel = speed * longint'(it.ftime) * 20;
      vert = (vel * 14 + 1280) / 2560;
      for (int k = 0; k < 3; k++) fwd[k] = shr_floor(dirv[k] * vel + (1 << 21), 22);
      rgt[0] = shr_floor(sidev[0] * vel + (1 << 21), 22);
      rgt[1] = 0;
      rgt[2] = shr_floor(sidev[1] * vel + (1 << 21), 22);
      if (it.keys[0]) for (int k = 0; k < 3; k++) nudge(k, fwd[k]);
      if (it.keys[1]) for (int k = 0; k < 3; k++) nudge(k, -fwd[k]);
      if (it.keys[2]) for (int k = 0; k < 3; k++) nudge(k, rgt[k]);
      if (it.keys[3]) for (int k = 0; k < 3; k++) nudge(k, -rgt[k]);
      if (it.keys[4]) nudge(1, vert);
      if (it.keys[5]) nudge(1, -vert);
    end
    cordic_sin_cos(yaw, sy, cy);
    cordic_sin_cos(pitch, sp, cp);
    dirv[0] = mulq14(cy, cp);
    dirv[1] = sp;
    dirv[2] = mulq14(sy, cp);
    sidev[0] = cp < 0 ? sy : -sy;
    sidev[1] = cp < 0 ? -cy : cy;
    upv[0] = mulq14(-sidev[1], dirv[1]);
    upv[1] = clip(shr_floor(sidev[1] * dirv[0] - sidev[0] * dirv[2] + 8192, 14),
                  -16384, 16384);
    upv[2] = mulq14(sidev[0], dirv[1]);
    v.px = 32'(posv[0]); v.py = 32'(posv[1]); v.pz = 32'(posv[2]);
    v.dx = 16'(dirv[0]); v.dy = 16'(dirv[1]); v.dz = 16'(dirv[2]);
    v.sdx = 16'(sidev[0]); v.sdz = 16'(sidev[1]);
    v.upx = 16'(upv[0]); v.upy = 16'(upv[1]); v.upz = 16'(upv[2]);
    v.yaw = 24'(yaw);
    expected_views.push_back(v);
  endtask

  // driver: offers pending items with random gaps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && in_fire) begin
        s_axis_tvalid <= 1'b0;
        send_gap <= $urandom_range(0, 5);
      end else if (!s_axis_tvalid) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        else if (pending_items.size() > 0) begin
          cam_item_t it;
          it = pending_items.pop_front();
          predict_view(it);
          s_axis_tdata <= {1'b0, it.ftime, it.keys, it.lim, it.cur_y, it.cur_x};
          s_axis_tuser <= it.cmd;
          s_axis_tvalid <= 1'b1;
        end
      end
    end
  end

  // receiver readiness with random stalls and the long hold-off
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if (take_gap > 0) begin
      m_axis_tready <= 1'b0;
      take_gap <= take_gap - 1;
    end else if (out_fire) begin
      take_gap <= $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= 1'b1;
  end

  // monitor: compares each result item with the oldest expected view
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    in_fire  <= rst_ni && s_axis_tvalid && s_axis_tready;
    out_fire <= rst_ni && m_axis_tvalid && m_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      cam_view_t got, want;
      got = m_axis_tdata;
      if (expected_views.size() == 0) begin
        fail_count++;
        if (mismatch_count++ < 10) $display("unexpected result item %h", got);
      end else begin
        want = expected_views.pop_front();
        if (got !== want) begin
          fail_count++;
          if (mismatch_count++ < 10) begin
            $display("mismatch exp px %0d py %0d pz %0d d %0d %0d %0d s %0d %0d u %0d %0d %0d y %0d",
                     want.px, want.py, want.pz, want.dx, want.dy, want.dz, want.sdx,
                     want.sdz, want.upx, want.upy, want.upz, want.yaw);
            $display("       got px %0d py %0d pz %0d d %0d %0d %0d s %0d %0d u %0d %0d %0d y %0d",
                     got.px, got.py, got.pz, got.dx, got.dy, got.dz, got.sdx,
                     got.sdz, got.upx, got.upy, got.upz, got.yaw);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > LimitCycles) begin
      $display("FAIL euler_fly_camera_orientation_core");
      $finish;
    end
  end

  function automatic cam_item_t mouse_item(int x, int y, bit lim);
    cam_item_t it;
    it = '0;
    it.cmd = CmdMouse; it.cur_x = 16'(x); it.cur_y = 16'(y); it.lim = lim;
    it.keys = 6'($urandom); it.ftime = 16'($urandom);
    return it;
  endfunction

  function automatic cam_item_t key_item(int keys, int ft);
    cam_item_t it;
    it = '0;
    it.cmd = CmdKeys; it.keys = 6'(keys); it.ftime = 16'(ft);
    it.cur_x = 16'($urandom); it.cur_y = 16'($urandom); it.lim = 1'($urandom);
    return it;
  endfunction

  task automatic write_reg(input logic idx, input int val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= 16'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegSens) sens = val; else speed = val;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_views.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    int cx, cy, sv[4], sp[4];
    reset_camera();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: first move, extremes, wraps, clamps, every key
    pending_items.push_back(mouse_item(-32768, 32767, 0));
    pending_items.push_back(key_item(6'h01, 16'hffff));
    pending_items.push_back(mouse_item(32767, -32768, 0));
    pending_items.push_back(mouse_item(-32768, 32767, 1));
    pending_items.push_back(mouse_item(-32768 + 400, 32767 - 200, 1));
    pending_items.push_back(mouse_item(-32768 + 400, 32767 - 500, 0));
    pending_items.push_back(mouse_item(-32768 + 700, 32767 - 900, 0));
    for (int k = 0; k < 6; k++) pending_items.push_back(key_item(1 << k, 16'hffff));
    pending_items.push_back(key_item(6'h3f, 0));
    pending_items.push_back(key_item(6'h00, 16'h8000));
    pending_items.push_back(mouse_item(0, 0, 1));
    pending_items.push_back(mouse_item(720, -360, 0));
    drain();

    sv = '{0, 65535, 256, 37};
    sp = '{65535, 0, 512, 26};
    cx = 0; cy = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(RegSens, sv[ph]);
      write_reg(RegSpeed, sp[ph]);
      for (int n = 0; n < 250; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          cx = $urandom; cy = $urandom;
          pending_items.push_back(mouse_item(cx, cy, 1'($urandom)));
        end else if ($urandom_range(0, 1)) begin
          cx += $signed($urandom_range(0, 400)) - 200;
          cy += $signed($urandom_range(0, 400)) - 200;
          cx = int'(clip(cx, -32768, 32767)); cy = int'(clip(cy, -32768, 32767));
          pending_items.push_back(mouse_item(cx, cy, $urandom_range(0, 3) != 0));
        end else
          pending_items.push_back(key_item($urandom_range(0, 63), $urandom));
      end
      if (ph == 1) begin
        // long receiver stall while the sender keeps offering
        repeat (10) @(posedge clk_i);
        hold_off = 1;
        repeat (600) @(posedge clk_i);
        hold_off = 0;
      end
      drain();
    end

    if (fail_count == 0 && expected_views.size() == 0)
      $display("PASS euler_fly_camera_orientation_core");
    else
      $display("FAIL euler_fly_camera_orientation_core");
    $finish;
  end

endmodule
